>>> hdl/cacs_pkg.sv
// Shared types and constants for the cycle-aligned sample capture block.
package cacs_pkg;

  // Capture geometry.
  localparam int NUM_BUFFERS  = 8;
  localparam int BUFFER_DEPTH = 256;
  localparam int SAMPLE_BITS  = 12;

  // Derived widths.
  localparam int BUF_IDX_W   = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int BUF_NUM_W   = $clog2(NUM_BUFFERS + 1);
  localparam int DEPTH_IDX_W = $clog2(BUFFER_DEPTH);
  localparam int LEN_W       = DEPTH_IDX_W + 1;
  localparam int STORE_DEPTH = NUM_BUFFERS * BUFFER_DEPTH;
  localparam int STORE_ADDR_W = BUF_IDX_W + DEPTH_IDX_W;

  // Configuration register.
  localparam int          PERIOD_W     = 16;
  localparam logic [15:0] PERIOD_RESET = 16'd200;

  // Result queue.
  localparam int OUT_FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);
  localparam int FIFO_LVL_W     = $clog2(OUT_FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_POLL  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    PH_START    = 4'b0001,
    PH_SAMPLING = 4'b0010,
    PH_WAITING  = 4'b0100,
    PH_EOC      = 4'b1000
  } phase_e;

  // One input word.
  typedef struct packed {
    logic [1:0]  command;
    logic        new_cycle;
    logic        timer_tick;
    logic [11:0] adc_sample;
    logic [2:0]  read_cycle;
    logic [7:0]  read_index;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic        end_of_capture;
    logic [11:0] read_data;
    logic [8:0]  read_length;
    logic        overflow;
  } out_word_t;

endpackage

>>> hdl/cacs_in_if.sv
// Valid/ready channel carrying input words.
interface cacs_in_if;
  logic               valid;
  logic               ready;
  cacs_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/cacs_out_if.sv
// Valid/ready channel carrying result words.
interface cacs_out_if;
  logic                valid;
  logic                ready;
  cacs_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/cycle_aligned_sample_capture_top.sv
// Top level of the cycle-aligned sample capture block.
//
// Input words arrive on in_i (valid/ready): a poll step, a clear or a read,
// together with the cycle mark, timer tick, converter sample and read address.
// Every accepted word produces exactly one result word on out_o (valid/ready),
// in order: end-of-capture, read data, read length and the overflow flag.
// The sample period is written through cfg_we_i / cfg_wdata_i; the user
// must write it only while idle, which the block itself does not enforce.
// An accepted word passes the state update and store access, then the
// result queue. One word is accepted every cycle while the queue has room;
// the single store port and the registered store read set this rate.
// A three-word result queue sits before out_o, so a stalled receiver does not
// stop intake until three words wait in the read stage and the queue
// together; in_i.ready then drops and no word is lost.
// Reset returns the block to the start state, clears the buffer lengths,
// the overflow flag, the pending mark and the period count, and loads the
// sample period with 200. The sample store is not cleared; only written
// entries are ever returned.
module cycle_aligned_sample_capture_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cacs_pkg::PERIOD_W-1:0] cfg_wdata_i,
  cacs_in_if.sink                       in_i,
  cacs_out_if.source                    out_o
);

  logic                              push;
  cacs_pkg::out_word_t               push_data;
  logic [cacs_pkg::FIFO_LVL_W-1:0]   fifo_level;

  // Capture state and store.
  cacs_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fifo_level_i (fifo_level),
    .in_i         (in_i),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // Result queue.
  cacs_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .level_o     (fifo_level),
    .out_o       (out_o)
  );

endmodule

>>> hdl/cacs_ram.sv
// Generic single-port RAM with registered read data.
module cacs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write when enabled, and always register the addressed entry.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/cacs_out_fifo.sv
// Small result queue that decouples the capture core from the receiver.
module cacs_out_fifo (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  input  cacs_pkg::out_word_t                   push_data_i,
  output logic [cacs_pkg::FIFO_LVL_W-1:0]       level_o,
  cacs_out_if.source                            out_o
);

  cacs_pkg::out_word_t                   entry_q [cacs_pkg::OUT_FIFO_DEPTH];
  logic [cacs_pkg::FIFO_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [cacs_pkg::FIFO_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [cacs_pkg::FIFO_LVL_W-1:0]       level_q, level_d;
  logic                                  pop;

  localparam logic [cacs_pkg::FIFO_PTR_W-1:0] LastPtr =
    cacs_pkg::FIFO_PTR_W'(cacs_pkg::OUT_FIFO_DEPTH - 1);

  assign pop = out_o.valid && out_o.ready;

  // Pointer and level bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      level_d = level_q + 1'b1;
    end else if (pop && !push_i) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign out_o.valid = (level_q != '0);
  assign out_o.data  = entry_q[rd_ptr_q];
  assign level_o     = level_q;

  // The core must never push into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (level_q != cacs_pkg::FIFO_LVL_W'(cacs_pkg::OUT_FIFO_DEPTH)) || pop)
    else $error("result queue overrun");

endmodule

>>> hdl/cacs_core.sv
// Capture state, sample store and read pipeline of the sample capture block.
module cacs_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [cacs_pkg::PERIOD_W-1:0]         cfg_wdata_i,
  input  logic [cacs_pkg::FIFO_LVL_W-1:0]       fifo_level_i,
  cacs_in_if.sink                               in_i,
  output logic                                  push_o,
  output cacs_pkg::out_word_t                   push_data_o
);

  localparam int LenW  = cacs_pkg::LEN_W;
  localparam int NumW  = cacs_pkg::BUF_NUM_W;
  localparam int IdxW  = cacs_pkg::BUF_IDX_W;
  localparam int DIdxW = cacs_pkg::DEPTH_IDX_W;
  localparam int FIFO_SUM_W = cacs_pkg::FIFO_LVL_W + 1;

  // Result fields waiting for the store's read data.
  typedef struct packed {
    logic            eoc;
    logic            overflow;
    logic [LenW-1:0] read_length;
    logic            data_ok;
  } s1_word_t;

  logic [cacs_pkg::PERIOD_W-1:0] period_q;
  cacs_pkg::phase_e              phase_q, phase_d;
  logic                          pend_q, pend_d;
  logic [NumW-1:0]               bnum_q, bnum_d;
  logic [cacs_pkg::PERIOD_W-1:0] pcount_q, pcount_d;
  logic [LenW-1:0]               cur_len_q, cur_len_d;
  logic [LenW-1:0]               len_q [cacs_pkg::NUM_BUFFERS];
  logic [LenW-1:0]               len_d [cacs_pkg::NUM_BUFFERS];
  logic                          ovf_q, ovf_d;
  logic                          s1_valid_q;
  s1_word_t                      s1_q, s1_d;

  logic                                   accept;
  logic                                   ram_we;
  logic [cacs_pkg::STORE_ADDR_W-1:0]      ram_addr;
  logic [cacs_pkg::SAMPLE_BITS-1:0]       ram_rdata;
  logic [LenW-1:0]                        slot;
  logic                                   cyc_ok;
  logic [LenW-1:0]                        rd_len;
  logic [FIFO_SUM_W-1:0]                  backlog;

  // Take a word only when the queue has room for every word in flight.
  assign backlog    = FIFO_SUM_W'(fifo_level_i) + FIFO_SUM_W'(s1_valid_q);
  assign in_i.ready = (backlog < FIFO_SUM_W'(cacs_pkg::OUT_FIFO_DEPTH));
  assign accept     = in_i.valid && in_i.ready;

  // Read side of the buffer lengths.
  assign cyc_ok = (32'(in_i.data.read_cycle) < cacs_pkg::NUM_BUFFERS);
  assign rd_len = cyc_ok ? len_q[in_i.data.read_cycle[IdxW-1:0]] : '0;

  // One step of the capture sequence for the word being accepted.
  always_comb begin
    phase_d   = phase_q;
    pend_d    = pend_q | in_i.data.new_cycle;
    bnum_d    = bnum_q;
    pcount_d  = pcount_q;
    cur_len_d = cur_len_q;
    len_d     = len_q;
    ovf_d     = ovf_q;
    ram_we    = 1'b0;
    slot      = cur_len_q;
    ram_addr  = {in_i.data.read_cycle[IdxW-1:0], in_i.data.read_index[DIdxW-1:0]};

    if (in_i.data.timer_tick && (pcount_q != '0)) begin
      pcount_d = pcount_q - 1'b1;
    end

    case (cacs_pkg::cmd_e'(in_i.data.command))
      cacs_pkg::CMD_POLL: begin
        case (phase_q)
          cacs_pkg::PH_START: begin
            if (pend_d) begin
              phase_d = cacs_pkg::PH_SAMPLING;
            end
          end
          cacs_pkg::PH_SAMPLING: begin
            if (pend_d) begin
              // A cycle mark opens the next buffer, which is always empty.
              pend_d = 1'b0;
              bnum_d = bnum_q + 1'b1;
              slot   = '0;
            end
            if (bnum_d == NumW'(cacs_pkg::NUM_BUFFERS)) begin
              phase_d = cacs_pkg::PH_EOC;
            end else begin
              pcount_d = period_q;
              ram_addr = {bnum_d[IdxW-1:0], slot[DIdxW-1:0]};
              if (slot < LenW'(cacs_pkg::BUFFER_DEPTH)) begin
                ram_we               = 1'b1;
                cur_len_d            = slot + 1'b1;
                len_d[bnum_d[IdxW-1:0]] = slot + 1'b1;
              end else begin
                cur_len_d = slot;
                ovf_d     = 1'b1;
              end
              phase_d = cacs_pkg::PH_WAITING;
            end
          end
          cacs_pkg::PH_WAITING: begin
            if ((pcount_d == '0) || pend_d) begin
              phase_d = cacs_pkg::PH_SAMPLING;
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
      end
      cacs_pkg::CMD_CLEAR: begin
        phase_d   = cacs_pkg::PH_START;
        bnum_d    = '0;
        cur_len_d = '0;
        ovf_d     = 1'b0;
        for (int i = 0; i < cacs_pkg::NUM_BUFFERS; i++) begin
          len_d[i] = '0;
        end
      end
      default: begin
        // Reads and the unused code only latch the mark and count the period down on a tick.
      end
    endcase

    s1_d.eoc         = (phase_d == cacs_pkg::PH_EOC);
    s1_d.overflow    = ovf_d;
    s1_d.read_length = '0;
    s1_d.data_ok     = 1'b0;
    if (in_i.data.command == cacs_pkg::CMD_READ) begin
      s1_d.read_length = rd_len;
      s1_d.data_ok     = ({1'b0, in_i.data.read_index} < rd_len);
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= cacs_pkg::PERIOD_RESET;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  // Capture state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= cacs_pkg::PH_START;
      pend_q    <= 1'b0;
      bnum_q    <= '0;
      pcount_q  <= '0;
      cur_len_q <= '0;
      ovf_q     <= 1'b0;
      for (int i = 0; i < cacs_pkg::NUM_BUFFERS; i++) begin
        len_q[i] <= '0;
      end
    end else if (accept) begin
      phase_q   <= phase_d;
      pend_q    <= pend_d;
      bnum_q    <= bnum_d;
      pcount_q  <= pcount_d;
      cur_len_q <= cur_len_d;
      ovf_q     <= ovf_d;
      len_q     <= len_d;
    end
  end

  // Sample store.
  cacs_ram #(
    .WIDTH (cacs_pkg::SAMPLE_BITS),
    .DEPTH (cacs_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (accept && ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_i.data.adc_sample[cacs_pkg::SAMPLE_BITS-1:0]),
    .rdata_o (ram_rdata)
  );

  // Stage that waits for the store's registered read data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  // Assemble the result word.
  assign push_o                     = s1_valid_q;
  assign push_data_o.end_of_capture = s1_q.eoc;
  assign push_data_o.read_data      = s1_q.data_ok ? 12'(ram_rdata) : '0;
  assign push_data_o.read_length    = s1_q.read_length;
  assign push_data_o.overflow       = s1_q.overflow;

  // Every accepted word yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted word produced no result");

  // The buffer number never passes the buffer count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bnum_q <= NumW'(cacs_pkg::NUM_BUFFERS))
    else $error("buffer number out of range");

  // End of capture is reached only with every buffer consumed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == cacs_pkg::PH_EOC) |-> (bnum_q == NumW'(cacs_pkg::NUM_BUFFERS)))
    else $error("end of capture with buffers left");

  // The current fill never passes the buffer depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_len_q <= LenW'(cacs_pkg::BUFFER_DEPTH))
    else $error("buffer fill beyond depth");

endmodule

>>> test/tb.sv
// Testbench for the cycle-aligned sample capture block: random poll, clear and read words.
`timescale 1ns / 1ps

module tb;
  import cacs_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 400;

  // Predicts every result word from the accepted input words and checks the block's output.
  class capture_scoreboard;
    phase_e      phase;
    bit          mark_pending;
    logic [3:0]  buf_num;
    logic [15:0] period;
    logic [15:0] period_count;
    logic [8:0]  lengths [NUM_BUFFERS];
    logic [11:0] store [STORE_DEPTH];
    bit          overflow_seen;
    out_word_t   expected [$];
    int          errors;

    function new();
      period       = PERIOD_RESET;
      period_count = '0;
      mark_pending = 1'b0;
      errors       = 0;
      restart();
    endfunction

    // A clear keeps the pending mark and the period count.
    function void restart();
      phase         = PH_START;
      buf_num       = '0;
      overflow_seen = 1'b0;
      foreach (lengths[i]) lengths[i] = '0;
    endfunction

    function void set_period(logic [15:0] value);
      period = value;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    // Apply one accepted word to the state and queue the result it yields.
    function void note_word(in_word_t w);
      out_word_t res;
      int        slot;
      res = '0;
      if (w.new_cycle) mark_pending = 1'b1;
      if (w.timer_tick && period_count != 0) period_count = period_count - 1'b1;
      case (w.command)
        CMD_POLL: begin
          case (phase)
            PH_START: begin
              if (mark_pending) phase = PH_SAMPLING;
            end
            PH_SAMPLING: begin
              if (mark_pending) begin
                mark_pending = 1'b0;
                buf_num = buf_num + 1'b1;
              end
              if (buf_num == NUM_BUFFERS) begin
                phase = PH_EOC;
              end else begin
                period_count = period;
                if (lengths[buf_num] < BUFFER_DEPTH) begin
                  slot = int'(buf_num) * BUFFER_DEPTH + int'(lengths[buf_num]);
                  store[slot] = w.adc_sample;
                  lengths[buf_num] = lengths[buf_num] + 1'b1;
                end else begin
                  overflow_seen = 1'b1;
                end
                phase = PH_WAITING;
              end
            end
            PH_WAITING: begin
              if (period_count == 0 || mark_pending) phase = PH_SAMPLING;
            end
            default: ;
          endcase
        end
        CMD_CLEAR: restart();
        CMD_READ: begin
          res.read_length = lengths[w.read_cycle];
          if (w.read_index < lengths[w.read_cycle]) begin
            slot = int'(w.read_cycle) * BUFFER_DEPTH + int'(w.read_index);
            res.read_data = store[slot];
          end
        end
        default: ;
      endcase
      res.end_of_capture = (phase == PH_EOC);
      res.overflow       = overflow_seen;
      expected.push_back(res);
    endfunction

    // Compare one result word with the oldest expectation.
    function void check_result(out_word_t got);
      out_word_t want;
      bit        bad;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result word with nothing expected: %h", got);
        return;
      end
      want = expected.pop_front();
      bad = (got.end_of_capture !== want.end_of_capture) ||
            (got.read_data !== want.read_data) ||
            (got.read_length !== want.read_length) ||
            (got.overflow !== want.overflow);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected eoc=%0d data=%h len=%0d ovf=%0d",
                   want.end_of_capture, want.read_data, want.read_length, want.overflow);
          $display("          got      eoc=%0d data=%h len=%0d ovf=%0d",
                   got.end_of_capture, got.read_data, got.read_length, got.overflow);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  cacs_in_if  in_if ();
  cacs_out_if out_if ();

  capture_scoreboard sb;
  int cycle_count;
  bit steady;
  bit hold_request;

  cycle_aligned_sample_capture_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial sb = new();

  // Watch both channels; the input word is noted before any result is checked.
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) sb.note_word(in_if.data);
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one, none at all during a steady stretch.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic in_word_t make_word(logic [1:0] cmd, bit mark, bit tick,
                                         logic [11:0] sample, logic [2:0] rcyc,
                                         logic [7:0] ridx);
    in_word_t w;
    w.command    = cmd;
    w.new_cycle  = mark;
    w.timer_tick = tick;
    w.adc_sample = sample;
    w.read_cycle = rcyc;
    w.read_index = ridx;
    return w;
  endfunction

  // Random word: mostly polls, some reads, rare clears and unused commands.
  function automatic in_word_t random_word(int mark_pm, int clear_pm);
    in_word_t w;
    int       r;
    w.new_cycle  = ($urandom_range(0, 999) < mark_pm);
    w.timer_tick = 1'($urandom_range(0, 1));
    w.adc_sample = 12'($urandom_range(0, 4095));
    w.read_cycle = 3'($urandom_range(0, 7));
    w.read_index = $urandom_range(0, 1) ? 8'($urandom_range(0, 7))
                                        : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 999);
    if (r < clear_pm) w.command = CMD_CLEAR;
    else if (r < clear_pm + 20) w.command = CMD_NONE;
    else if (r < clear_pm + 170) w.command = CMD_READ;
    else w.command = CMD_POLL;
    return w;
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.data  <= w;
    in_if.valid <= 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    sb.set_period(value);
    cfg_we_i <= 1'b0;
  endtask

  // One capture run: a clear carrying a cycle mark, then random words.
  task automatic run_capture(input int count, input int mark_pm, input int clear_pm);
    send_word(make_word(CMD_CLEAR, 1'b1, 1'($urandom_range(0, 1)),
                        12'($urandom_range(0, 4095)), 3'($urandom_range(0, 7)),
                        8'($urandom_range(0, 255))));
    for (int i = 0; i < count; i++) begin
      steady = ((i / 100) % 3 == 1);
      send_word(random_word(mark_pm, clear_pm));
    end
    steady = 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        int stall;
        stall = pick_gap();
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // Main sequence.
  initial begin
    in_word_t directed [$];
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= '0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cycle_count  <= 0;
    steady       = 1'b0;
    hold_request = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset period: empty reads, the unused command latching a mark,
    // the first mark opening sampling, a clear, and reads inside and beyond a length.
    directed.push_back(make_word(CMD_READ, 1'b0, 1'b0, 12'h000, 3'd0, 8'd0));
    directed.push_back(make_word(CMD_READ, 1'b0, 1'b0, 12'hFFF, 3'd7, 8'd255));
    directed.push_back(make_word(CMD_NONE, 1'b1, 1'b1, 12'h000, 3'd0, 8'd0));
    directed.push_back(make_word(CMD_POLL, 1'b0, 1'b0, 12'h000, 3'd0, 8'd0));
    directed.push_back(make_word(CMD_POLL, 1'b0, 1'b0, 12'hFFF, 3'd0, 8'd0));
    directed.push_back(make_word(CMD_POLL, 1'b0, 1'b1, 12'h123, 3'd0, 8'd0));
    directed.push_back(make_word(CMD_POLL, 1'b1, 1'b0, 12'h456, 3'd0, 8'd0));
    directed.push_back(make_word(CMD_POLL, 1'b0, 1'b0, 12'h000, 3'd0, 8'd0));
    directed.push_back(make_word(CMD_READ, 1'b0, 1'b0, 12'h000, 3'd1, 8'd0));
    directed.push_back(make_word(CMD_READ, 1'b0, 1'b0, 12'h000, 3'd1, 8'd1));
    directed.push_back(make_word(CMD_READ, 1'b0, 1'b0, 12'h000, 3'd2, 8'd0));
    directed.push_back(make_word(CMD_READ, 1'b0, 1'b0, 12'h000, 3'd2, 8'd255));
    directed.push_back(make_word(CMD_POLL, 1'b0, 1'b1, 12'h789, 3'd0, 8'd0));
    directed.push_back(make_word(CMD_CLEAR, 1'b0, 1'b0, 12'h000, 3'd0, 8'd0));
    directed.push_back(make_word(CMD_READ, 1'b0, 1'b0, 12'h000, 3'd1, 8'd0));
    directed.push_back(make_word(CMD_POLL, 1'b0, 1'b0, 12'h000, 3'd0, 8'd0));
    directed.push_back(make_word(CMD_POLL, 1'b1, 1'b0, 12'hA5A, 3'd0, 8'd0));
    directed.push_back(make_word(CMD_POLL, 1'b0, 1'b0, 12'h5A5, 3'd0, 8'd0));
    directed.push_back(make_word(CMD_READ, 1'b0, 1'b0, 12'h000, 3'd1, 8'd0));
    foreach (directed[i]) send_word(directed[i]);
    drain();

    // Zero period: one sample every two polls, no further marks, so buffer one overflows.
    write_period(16'd0);
    run_capture(700, 0, 0);
    drain();

    // Period of one with frequent marks, enough to reach end of capture.
    write_period(16'd1);
    run_capture(300, 40, 0);
    drain();

    // Longest period: only marks leave the waiting state; the receiver holds off meanwhile.
    write_period(16'hFFFF);
    hold_request = 1'b1;
    run_capture(200, 50, 0);
    drain();

    // A short random period with occasional clears.
    write_period(16'($urandom_range(2, 20)));
    run_capture(450, 20, 10);
    drain();
    repeat (10) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/cacs_pkg.sv
hdl/cacs_in_if.sv
hdl/cacs_out_if.sv
hdl/cacs_ram.sv
hdl/cacs_out_fifo.sv
hdl/cacs_core.sv
hdl/cycle_aligned_sample_capture_top.sv
test/tb.sv
